FILE: rtl/pec_pkg.sv
// shared constants and types of the priority evicting key-value cache
package pec_pkg;

  // default number of entries in the store
  localparam int unsigned ENTRIES_DEF = 16;

  // key, value and priority width
  localparam int unsigned KW = 32;

  // capacity register width and reset value
  localparam int unsigned CAPW = 5;
  localparam logic [CAPW-1:0] CAP_RESET = 5'd16;

  // operation codes
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_PUT   = 2'd1,
    OP_UPD   = 2'd2,
    OP_ERASE = 2'd3
  } op_e;

  // victim candidate handed from cell to cell
  typedef struct packed {
    logic          tok;
    logic          found;
    logic [KW-1:0] key;
    logic [KW-1:0] value;
    logic [KW-1:0] prio;
  } cand_t;

  // per-cell write controls
  typedef struct packed {
    logic fill;
    logic wr_value;
    logic wr_prio;
    logic clr;
  } cell_wr_t;

endpackage

FILE: rtl/pec_in_if.sv
// request channel: operation, key, value and priority
interface pec_in_if import pec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic signed [KW-1:0] key;
  logic signed [KW-1:0] value;
  logic signed [KW-1:0] priority_req;

  modport source (output valid, op, key, value, priority_req, input ready);
  modport sink   (input valid, op, key, value, priority_req, output ready);
endinterface

FILE: rtl/pec_out_if.sv
// result channel: hit, read value and evicted entry
interface pec_out_if import pec_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [KW-1:0] read_value;
  logic                 evicted;
  logic signed [KW-1:0] evicted_key;
  logic signed [KW-1:0] evicted_value;
  logic signed [KW-1:0] evicted_priority;

  modport source (output valid, hit, read_value, evicted, evicted_key, evicted_value,
                  evicted_priority, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, evicted_value,
                  evicted_priority, output ready);
endinterface

FILE: rtl/pec_cell.sv
// one store entry with key match and one stage of the victim search chain
module pec_cell import pec_pkg::*; #(
  parameter int unsigned IW       = 4,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_wr_t      wr_i,
  input  logic [KW-1:0] wr_key_i,
  input  logic [KW-1:0] wr_value_i,
  input  logic [KW-1:0] wr_prio_i,
  input  logic [KW-1:0] req_key_i,
  input  cand_t         cand_i,
  input  logic [IW-1:0] cand_idx_i,
  output cand_t         cand_o,
  output logic [IW-1:0] cand_idx_o,
  output logic          valid_o,
  output logic          match_o,
  output logic [KW-1:0] value_o
);

  logic          valid_q;
  logic [KW-1:0] key_q;
  logic [KW-1:0] value_q;
  logic [KW-1:0] prio_q;
  cand_t         cand_q;
  cand_t         cand_d;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] idx_d;
  logic          take;
  logic          prio_lt;
  logic          prio_eq;
  logic          key_lt;

  // entry valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.fill) begin
      valid_q <= 1'b1;
    end else if (wr_i.clr) begin
      valid_q <= 1'b0;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    if (wr_i.fill) begin
      key_q <= wr_key_i;
    end
    if (wr_i.fill || wr_i.wr_value) begin
      value_q <= wr_value_i;
    end
    if (wr_i.fill || wr_i.wr_prio) begin
      prio_q <= wr_prio_i;
    end
  end

  // key match
  assign match_o = valid_q && (key_q == req_key_i);
  assign valid_o = valid_q;
  assign value_o = value_q;

  // lower priority goes first, ties to the lower key
  assign prio_lt = $signed(prio_q) < $signed(cand_i.prio);
  assign prio_eq = prio_q == cand_i.prio;
  assign key_lt  = $signed(key_q) < $signed(cand_i.key);
  assign take    = valid_q && (!cand_i.found || prio_lt || (prio_eq && key_lt));

  // candidate passed on to the next cell
  always_comb begin
    cand_d = cand_i;
    idx_d  = cand_idx_i;
    if (take) begin
      cand_d.found = 1'b1;
      cand_d.key   = key_q;
      cand_d.value = value_q;
      cand_d.prio  = prio_q;
      idx_d        = IW'(CELL_IDX);
    end
  end

  // chain stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      idx_q  <= '0;
    end else begin
      cand_q <= cand_d;
      idx_q  <= idx_d;
    end
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = idx_q;

endmodule

FILE: rtl/priority_evicting_key_value_cache.sv
// top level: fully associative key-value cache with lowest priority eviction
//
//   channel  | dir | beat
//   ---------+-----+------------------------------------------------------------
//   in_i     | in  | op, key, value, priority_req (valid/ready)
//   out_o    | out | hit, read_value, evicted, evicted_key/value/priority
//   cfg      | in  | cfg_we_i, cfg_wdata_i: capacity, no handshake
//
// get, update, erase and a put without eviction pass through the idle and lookup states.
// a put that evicts also runs the victim search: the search token walks
// the row of cells, one cell per cycle.
// rst_ni clears all valid bits, the entry count and capacity goes to 16.
// a waiting result holds the block in its lookup cycle until out_o is ready;
// one request may be taken while the result register is still full.
module priority_evicting_key_value_cache import pec_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CAPW-1:0] cfg_wdata_i,
  pec_in_if.sink          in_i,
  pec_out_if.source       out_o
);

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAPW) ? CW : CAPW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN
  } state_e;

  state_e          state_q;
  logic [1:0]      op_q;
  logic [KW-1:0]   key_q;
  logic [KW-1:0]   value_q;
  logic [KW-1:0]   prio_q;
  logic [CW-1:0]   count_q;
  logic [CAPW-1:0] cap_q;

  logic            out_valid_q;
  logic            hit_q;
  logic [KW-1:0]   read_value_q;
  logic            evicted_q;
  logic [KW-1:0]   ev_key_q;
  logic [KW-1:0]   ev_value_q;
  logic [KW-1:0]   ev_prio_q;

  cand_t           chain [ENTRIES+1];
  logic [IW-1:0]   chain_idx [ENTRIES+1];
  cell_wr_t        wr [ENTRIES];
  logic [KW-1:0]   cell_value [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] free_oh;

  logic            slot_free;
  logic            look_go;
  logic            hit;
  logic [KW-1:0]   read_value;
  logic [CMPW-1:0] cap_ext;
  logic [CMPW-1:0] cap_eff;
  logic            count_ge;
  logic            new_put;
  logic            scan_start;
  logic            scan_done;
  logic            fill_free;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // head of the victim search chain
  assign chain[0]     = '{tok: scan_start, found: 1'b0, key: '0, value: '0, prio: '0};
  assign chain_idx[0] = '0;

  // row of entry cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pec_cell #(
      .IW       (IW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (wr[g]),
      .wr_key_i   (key_q),
      .wr_value_i (value_q),
      .wr_prio_i  (prio_q),
      .req_key_i  (key_q),
      .cand_i     (chain[g]),
      .cand_idx_i (chain_idx[g]),
      .cand_o     (chain[g+1]),
      .cand_idx_o (chain_idx[g+1]),
      .valid_o    (valid[g]),
      .match_o    (match[g]),
      .value_o    (cell_value[g])
    );
  end

  // hit and value of the matching entry
  assign hit = |match;
  always_comb begin
    read_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        read_value = read_value | cell_value[i];
      end
    end
  end

  // lowest free entry
  assign free_oh = ~valid & (valid + ENTRIES'(1));

  // effective capacity, saturated to the store size
  assign cap_ext  = CMPW'(cap_q);
  assign cap_eff  = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
  assign count_ge = CMPW'(count_q) >= cap_eff;

  // control decisions
  assign slot_free  = !out_valid_q || out_o.ready;
  assign look_go    = (state_q == S_LOOK) && slot_free;
  assign new_put    = (op_e'(op_q) == OP_PUT) && !hit && (cap_q != '0);
  assign scan_start = look_go && new_put && count_ge;
  assign fill_free  = look_go && new_put && !count_ge;
  assign scan_done  = (state_q == S_SCAN) && chain[ENTRIES].tok;

  // per-cell write controls
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      wr[i] = '0;
      if (look_go) begin
        case (op_e'(op_q))
          OP_PUT: begin
            wr[i].wr_value = match[i];
            wr[i].wr_prio  = match[i];
            wr[i].fill     = fill_free && free_oh[i];
          end
          OP_UPD: begin
            wr[i].wr_prio = match[i];
          end
          OP_ERASE: begin
            wr[i].clr = match[i];
          end
          default: begin
            wr[i] = '0;
          end
        endcase
      end
      if (scan_done && (chain_idx[ENTRIES] == IW'(i))) begin
        wr[i].fill = 1'b1;
      end
    end
  end

  // sequencer, request, count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      key_q        <= '0;
      value_q      <= '0;
      prio_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
      read_value_q <= '0;
      evicted_q    <= 1'b0;
      ev_key_q     <= '0;
      ev_value_q   <= '0;
      ev_prio_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            op_q    <= in_i.op;
            key_q   <= in_i.key;
            value_q <= in_i.value;
            prio_q  <= in_i.priority_req;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (look_go) begin
            state_q <= scan_start ? S_SCAN : S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // entry count
      if (fill_free) begin
        count_q <= count_q + CW'(1);
      end else if (look_go && (op_e'(op_q) == OP_ERASE) && hit) begin
        count_q <= count_q - CW'(1);
      end

      // result register
      if (look_go && !scan_start) begin
        out_valid_q  <= 1'b1;
        hit_q        <= hit;
        read_value_q <= ((op_e'(op_q) == OP_GET) && hit) ? read_value : '0;
        evicted_q    <= 1'b0;
        ev_key_q     <= '0;
        ev_value_q   <= '0;
        ev_prio_q    <= '0;
      end else if (scan_done) begin
        out_valid_q  <= 1'b1;
        hit_q        <= 1'b0;
        read_value_q <= '0;
        evicted_q    <= 1'b1;
        ev_key_q     <= chain[ENTRIES].key;
        ev_value_q   <= chain[ENTRIES].value;
        ev_prio_q    <= chain[ENTRIES].prio;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // channel outputs
  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.hit              = hit_q;
  assign out_o.read_value       = read_value_q;
  assign out_o.evicted          = evicted_q;
  assign out_o.evicted_key      = ev_key_q;
  assign out_o.evicted_value    = ev_value_q;
  assign out_o.evicted_priority = ev_prio_q;

  // count tracks the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == int'(count_q))
    else $error("entry count differs from number of valid entries");

  // a key is held by one entry at most
  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("key matches more than one entry");

  // the search only runs while the result register is empty
  a_scan_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !out_valid_q)
    else $error("victim search with a pending result");

  // a finished search always has a victim
  a_scan_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> chain[ENTRIES].found)
    else $error("victim search finished without a victim");

  // a search starts only when the store is not empty
  a_scan_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |-> (count_q != '0))
    else $error("eviction started on an empty store");

endmodule
